FILE: rtl/pef_pkg.sv
// ----------------------------------------------------------------------------
// pef_pkg - shared types and constants of the polygon edge-flag fill block
// Grid geometry, coordinate formats, command and register codes, FSM states.
// ----------------------------------------------------------------------------
package pef_pkg;

  // Grid and number formats
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W     = 2;
  localparam int FLAG_BIT   = 1;
  localparam int INSIDE_BIT = 0;
  localparam int COORD_W    = 24;
  localparam int CMD_W      = 3;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int SLOPE_FRAC = 16;
  localparam int DX_W       = 32;
  localparam int NUM_W      = COORD_W + SLOPE_FRAC;
  localparam int DEN_W      = COORD_W;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int PROD_W     = COORD_W + 1 + DX_W;
  localparam int X_W        = 52;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     GRID_RESET      = CFG_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST = 3'd0,
    CMD_NEXT  = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } pef_cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_CHK,
    S_EDGE_DIV,
    S_EDGE_MUL,
    S_EDGE_X,
    S_EDGE_ROW,
    S_EDGE_WR,
    S_FILL,
    S_FILL_DRAIN,
    S_READ,
    S_DONE
  } pef_state_e;

endpackage

FILE: rtl/pef_intf.sv
// ----------------------------------------------------------------------------
// pef_intf - channel interfaces of the polygon edge-flag fill block
// Command items in, result items out, configuration writes.
// ----------------------------------------------------------------------------
interface pef_cmd_if;
  import pef_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic [ROW_W-1:0]          read_row;
  logic [COL_W-1:0]          read_col;

  modport source (output valid, command, vertex_x, vertex_y, read_row, read_col,
                  input ready);
  modport sink (input valid, command, vertex_x, vertex_y, read_row, read_col,
                output ready);
endinterface

interface pef_res_if;
  logic valid;
  logic ready;
  logic status;
  logic cell_inside;

  modport source (output valid, status, cell_inside, input ready);
  modport sink (input valid, status, cell_inside, output ready);
endinterface

interface pef_cfg_if;
  import pef_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/polygon_edge_flag_fill.sv
// ----------------------------------------------------------------------------
// polygon_edge_flag_fill - even-odd polygon rasterizer into a cell mask
// Edge-flag method over a 256 x 256 mask of 2-bit cells held in one RAM.
// ----------------------------------------------------------------------------
// Channels: cmd_if carries one command item (first vertex, next vertex, end
// polygon and fill, read cell, clear mask); res_if returns exactly one result
// item per command; cfg_if writes grid_width (index 0) and grid_height
// (index 1) and is always ready.
// Flow: one item at a time; no new command is taken until the last one is
// done. A next vertex runs the bit-serial slope divider, then walks each row
// the edge crosses (read, then write back the toggled flag). A fill sweeps
// width * height cells at one cell per cycle through the RAM port pair. A
// clear writes every cell.
// Reset: a clearing pass writes all 65536 cells to zero; cmd_if.ready stays
// low during that pass while cfg_if writes are taken.
// Stall: a finished result waits in the output register; while that register
// is full, the block holds in S_DONE until the receiver takes the old result.
// ----------------------------------------------------------------------------
module polygon_edge_flag_fill
  import pef_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  pef_cfg_if.sink  cfg_if,
  pef_cmd_if.sink  cmd_if,
  pef_res_if.source res_if
);

  pef_state_e state_q, state_d;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  logic                      open_q;
  logic signed [COORD_W-1:0] last_x_q, last_y_q;
  logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
  logic                      dx_neg_q;
  logic signed [DX_W-1:0]    dx_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [X_W-1:0]     x_q;
  logic [ROW_W:0]            y_q;
  logic [ROW_W-1:0]          ymax_q;
  logic [ADDR_W-1:0]         edge_addr_q;

  logic [ROW_W-1:0]  fr_q;
  logic [COL_W-1:0]  fc_q;
  logic              p_valid_q, p_first_q, par_q;
  logic [ADDR_W-1:0] p_addr_q;
  logic              fill_in;
  logic              fill_last;

  logic [ADDR_W-1:0] clr_cnt_q;
  logic              clr_cmd_q;

  logic res_status_q, res_cell_q;
  logic out_valid_q, out_status_q, out_cell_q;
  logic out_load;

  logic              in_acc;
  pef_cmd_e          cmd;
  logic              fill_empty;
  logic              reject;
  logic signed [COORD_W:0] fw8, h256, dxs, dys, neg_ay, ay_rnd;
  logic [COORD_W-1:0]      bym1;
  logic [COORD_W-1:0]      dx_mag;
  logic [COORD_W-1:0]      mul_m;
  logic signed [X_W-1:0]   fw16;
  logic signed [X_W-1:0]   dx_ext;
  logic                    x_neg, x_in, toggle;
  logic [COL_W-1:0]        edge_col;
  logic [ROW_W:0]          y_start;
  logic [COORD_W-ROW_W-FRAC_BITS+ROW_W-1:0] yq_full;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_quo;
  logic signed [DX_W-1:0]  dx_sat;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Effective grid size
  always_comb begin
    w_eff = (width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_q;
    h_eff = (height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q;
    w_m1  = COL_W'(w_eff - 1'b1);
    h_m1  = ROW_W'(h_eff - 1'b1);
    fill_empty = (w_eff == '0) || (h_eff == '0);
  end

  assign in_acc       = cmd_if.valid && cmd_if.ready;
  assign cmd_if.ready = (state_q == S_IDLE);
  assign cmd          = pef_cmd_e'(cmd_if.command);
  assign cfg_if.ready = 1'b1;

  // Edge rejection and divider operands
  always_comb begin
    fw8    = $signed({{(COORD_W+1-CFG_W-FRAC_BITS){1'b0}}, w_eff - 1'b1,
                      {FRAC_BITS{1'b0}}});
    h256   = $signed({{(COORD_W+1-CFG_W-FRAC_BITS){1'b0}}, h_eff, {FRAC_BITS{1'b0}}});
    dxs    = {bx_q[COORD_W-1], bx_q} - {ax_q[COORD_W-1], ax_q};
    dys    = {by_q[COORD_W-1], by_q} - {ay_q[COORD_W-1], ay_q};
    dx_mag = dxs[COORD_W] ? COORD_W'(-dxs) : COORD_W'(dxs);
    reject = fill_empty || (ay_q == by_q)
             || (($signed({ax_q[COORD_W-1], ax_q}) >= fw8)
                 && ($signed({bx_q[COORD_W-1], bx_q}) >= fw8))
             || ($signed({ay_q[COORD_W-1], ay_q}) > h256)
             || (by_q <= 0);
  end

  assign div_start = (state_q == S_EDGE_CHK) && !reject;

  pef_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({dx_mag, {SLOPE_FRAC{1'b0}}}),
    .divisor_i  (dys[COORD_W-1:0]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Saturate the signed slope to 16.16
  always_comb begin
    if (!dx_neg_q) begin
      dx_sat = (div_quo[NUM_W-1:DX_W-1] != '0) ? {1'b0, {(DX_W-1){1'b1}}}
                                               : $signed(div_quo[DX_W-1:0]);
    end else if ((div_quo[NUM_W-1:DX_W] != '0)
                 || (div_quo[DX_W-1] && (div_quo[DX_W-2:0] != '0))) begin
      dx_sat = {1'b1, {(DX_W-1){1'b0}}};
    end else begin
      dx_sat = $signed(DX_W'(0) - div_quo[DX_W-1:0]);
    end
  end

  // Start offset, first row and last row
  always_comb begin
    neg_ay  = -{ay_q[COORD_W-1], ay_q};
    mul_m   = ay_q[COORD_W-1] ? neg_ay[COORD_W-1:0]
                              : {{(COORD_W-FRAC_BITS){1'b0}}, neg_ay[FRAC_BITS-1:0]};
    ay_rnd  = {ay_q[COORD_W-1], ay_q} + (COORD_W+1)'((1 << FRAC_BITS) - 1);
    y_start = ay_q[COORD_W-1] ? '0 : ay_rnd[FRAC_BITS +: ROW_W+1];
    bym1    = by_q - 1'b1;
    yq_full = bym1[COORD_W-1:FRAC_BITS];
  end

  // Per-row crossing classification
  always_comb begin
    fw16     = $signed({{(X_W-CFG_W-SLOPE_FRAC){1'b0}}, w_eff - 1'b1,
                        {SLOPE_FRAC{1'b0}}});
    dx_ext   = {{(X_W-DX_W){dx_q[DX_W-1]}}, dx_q};
    x_neg    = x_q[X_W-1];
    x_in     = !x_neg && (x_q < fw16);
    toggle   = x_neg || x_in;
    edge_col = x_neg ? '0 : (x_q[SLOPE_FRAC +: COL_W] + 1'b1);
  end

  // Fill pipe parity
  assign fill_in   = (p_first_q ? 1'b0 : par_q) ^ ram_rdata[FLAG_BIT];
  assign fill_last = (fc_q == w_m1) && (fr_q == h_m1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == '1) state_d = clr_cmd_q ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_NEXT:  state_d = open_q ? S_EDGE_CHK : S_DONE;
            CMD_FILL:  state_d = (open_q && !fill_empty) ? S_FILL : S_DONE;
            CMD_READ:  state_d = S_READ;
            CMD_CLEAR: state_d = S_CLEAR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_EDGE_CHK:   state_d = reject ? S_DONE : S_EDGE_DIV;
      S_EDGE_DIV: begin
        if (div_done) state_d = S_EDGE_MUL;
      end
      S_EDGE_MUL:   state_d = S_EDGE_X;
      S_EDGE_X:     state_d = S_EDGE_ROW;
      S_EDGE_ROW: begin
        if (y_q > {1'b0, ymax_q}) state_d = S_DONE;
        else if (toggle) state_d = S_EDGE_WR;
      end
      S_EDGE_WR:    state_d = S_EDGE_ROW;
      S_FILL: begin
        if (fill_last) state_d = S_FILL_DRAIN;
      end
      S_FILL_DRAIN: state_d = S_DONE;
      S_READ:       state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || res_if.ready) state_d = S_IDLE;
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {fr_q, fc_q};
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_q == S_EDGE_WR) begin
      ram_we    = 1'b1;
      ram_waddr = edge_addr_q;
      ram_wdata = ram_rdata ^ CELL_W'(1 << FLAG_BIT);
    end else if (p_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = p_addr_q;
      ram_wdata = CELL_W'(ram_rdata[INSIDE_BIT] | fill_in);
    end
    if (state_q == S_IDLE && in_acc && cmd == CMD_READ) begin
      ram_re    = 1'b1;
      ram_raddr = {cmd_if.read_row, cmd_if.read_col};
    end else if (state_q == S_EDGE_ROW) begin
      ram_re    = toggle && (y_q <= {1'b0, ymax_q});
      ram_raddr = {y_q[ROW_W-1:0], edge_col};
    end else if (state_q == S_FILL) begin
      ram_re = 1'b1;
    end
  end

  pef_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_mask (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || res_if.ready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      width_q     <= GRID_RESET;
      height_q    <= GRID_RESET;
      open_q      <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      clr_cnt_q   <= '0;
      clr_cmd_q   <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Configuration writes
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_GRID_WIDTH) width_q <= cfg_if.data;
        else if (cfg_if.index == REG_GRID_HEIGHT) height_q <= cfg_if.data;
      end
      // Polygon chain state
      if (in_acc) begin
        if (cmd == CMD_FIRST || (cmd == CMD_NEXT && open_q)) begin
          open_q   <= 1'b1;
          last_x_q <= cmd_if.vertex_x;
          last_y_q <= cmd_if.vertex_y;
        end else if (cmd == CMD_FILL) begin
          open_q <= 1'b0;
        end
      end
      // Clearing sweep
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (in_acc && cmd == CMD_CLEAR) begin
        clr_cnt_q <= '0;
        clr_cmd_q <= 1'b1;
      end
      // Fill pipe valid
      p_valid_q <= (state_q == S_FILL);
      // Output register
      if (out_load) out_valid_q <= 1'b1;
      else if (res_if.ready) out_valid_q <= 1'b0;
    end
  end

  // Edge datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (last_y_q < cmd_if.vertex_y) begin
        ax_q <= last_x_q;
        ay_q <= last_y_q;
        bx_q <= cmd_if.vertex_x;
        by_q <= cmd_if.vertex_y;
      end else begin
        ax_q <= cmd_if.vertex_x;
        ay_q <= cmd_if.vertex_y;
        bx_q <= last_x_q;
        by_q <= last_y_q;
      end
    end
    if (state_q == S_EDGE_CHK) dx_neg_q <= dxs[COORD_W];
    if (state_q == S_EDGE_DIV && div_done) dx_q <= dx_sat;
    if (state_q == S_EDGE_MUL) prod_q <= $signed({1'b0, mul_m}) * dx_q;
    if (state_q == S_EDGE_X) begin
      x_q    <= $signed({{(X_W-COORD_W-SLOPE_FRAC+FRAC_BITS){ax_q[COORD_W-1]}}, ax_q,
                         {(SLOPE_FRAC-FRAC_BITS){1'b0}}})
              + $signed({{(X_W-PROD_W+FRAC_BITS){prod_q[PROD_W-1]}},
                         prod_q[PROD_W-1:FRAC_BITS]});
      y_q    <= y_start;
      ymax_q <= (yq_full > $bits(yq_full)'(h_m1)) ? h_m1 : ROW_W'(yq_full);
    end
    if (state_q == S_EDGE_ROW) edge_addr_q <= ram_raddr;
    if ((state_q == S_EDGE_ROW && !toggle) || state_q == S_EDGE_WR) begin
      x_q <= x_q + dx_ext;
      y_q <= y_q + 1'b1;
    end
  end

  // Fill datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fr_q <= '0;
      fc_q <= '0;
    end else if (state_q == S_FILL) begin
      p_addr_q  <= {fr_q, fc_q};
      p_first_q <= (fc_q == '0);
      if (fc_q == w_m1) begin
        fc_q <= '0;
        fr_q <= fr_q + 1'b1;
      end else begin
        fc_q <= fc_q + 1'b1;
      end
    end
    if (p_valid_q) par_q <= fill_in;
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_status_q <= (cmd == CMD_NEXT || cmd == CMD_FILL) && !open_q;
      res_cell_q   <= 1'b0;
    end
    if (state_q == S_READ) res_cell_q <= ram_rdata[INSIDE_BIT];
    if (out_load) begin
      out_status_q <= res_status_q;
      out_cell_q   <= res_cell_q;
    end
  end

  assign res_if.valid       = out_valid_q;
  assign res_if.status      = out_status_q;
  assign res_if.cell_inside = out_cell_q;

  // Flag write-back goes to the cell read in the previous cycle
  a_rmw_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDGE_WR) |-> (ram_waddr == $past(ram_raddr)))
    else $error("edge write-back address differs from read address");

  // One item in flight at a time
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !cmd_if.ready)
    else $error("command accepted while another is in flight");

  // Fill pipe writes only during a fill pass
  a_pipe_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (state_q == S_FILL || state_q == S_FILL_DRAIN))
    else $error("fill pipe active outside fill pass");

  // Edge walk never toggles past the last row
  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDGE_WR) |-> (y_q <= {1'b0, ymax_q}))
    else $error("edge walk beyond last row");

endmodule

FILE: rtl/pef_ram.sv
// ----------------------------------------------------------------------------
// pef_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pef_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/pef_div.sv
// ----------------------------------------------------------------------------
// pef_div - iterative unsigned divider for the edge slope
// Restoring division, one quotient bit per cycle, NUM_W quotient bits per divide.
// ----------------------------------------------------------------------------
module pef_div
  import pef_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_d;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic             ge;

  // One restoring step
  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
